// File: design/mabsg_pkg.sv
// ----------------------------------------------------------------------------
// mabsg_pkg
// Shared types and constants of the multi-axis step pulse generator.
// ----------------------------------------------------------------------------
package mabsg_pkg;

  localparam int unsigned AxesDef       = 6;
  localparam int unsigned QueueDepthDef = 8;

  localparam int unsigned OpW    = 3;
  localparam int unsigned AxIdxW = 3;
  localparam int unsigned StepsW = 31;
  localparam int unsigned TicksW = 16;
  localparam int unsigned PosW   = 32;
  localparam int unsigned ErrW   = 32;

  // operation codes of an input beat
  typedef enum logic [OpW-1:0] {
    OP_LOAD_AXIS = 3'd0,
    OP_START_BLK = 3'd1,
    OP_PUSH_SEG  = 3'd2,
    OP_TICK      = 3'd3,
    OP_SET_POS   = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INIT,
    ST_SEG,
    ST_BLK,
    ST_AXIS,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

// File: design/multi_axis_bresenham_step_generator.sv
// ----------------------------------------------------------------------------
// multi_axis_bresenham_step_generator
// Bresenham step generator: block table and segment queue held in memories.
// ----------------------------------------------------------------------------
// One input beat is taken at a time and answered by exactly one output beat.
// Load, push, set position, clear and a tick on an idle empty queue pass
// through the EXEC and OUT states; start block adds an INIT sweep that seeds
// the per-axis error words; a tick runs the BLK and FIN states for a dwell
// segment and adds an AXIS sweep for a motion segment (and a SEG state when
// it loads a new segment), paced by the single read and write port of the
// per-axis step and error memories, one axis per cycle.
// A new beat is taken once the previous result has been handed over.
module multi_axis_bresenham_step_generator
  import mabsg_pkg::*;
#(
  parameter int unsigned AXES        = mabsg_pkg::AxesDef,
  parameter int unsigned QUEUE_DEPTH = mabsg_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [AXES-1:0]                  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mabsg_pkg::OpW-1:0]        op_i,
  input  logic [mabsg_pkg::AxIdxW-1:0]     axis_index_i,
  input  logic [mabsg_pkg::StepsW-1:0]     axis_steps_i,
  input  logic [AXES-1:0]                  dir_bits_i,
  input  logic [mabsg_pkg::StepsW-1:0]     total_steps_i,
  input  logic [mabsg_pkg::TicksW-1:0]     segment_ticks_i,
  input  logic                             has_motion_i,
  input  logic                             last_of_block_i,
  input  logic [mabsg_pkg::PosW-1:0]       position_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [AXES-1:0]                  step_pins_o,
  output logic [AXES-1:0]                  dir_pins_o,
  output logic                             running_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count_o,
  output logic                             rejected_o,
  output logic                             segment_done_o,
  output logic [mabsg_pkg::PosW-1:0]       axis_position_o
);
  import mabsg_pkg::*;

  localparam int unsigned SlotW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH * AXES);
  localparam int unsigned AxW   = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned IdxW  = $clog2(AXES + 1);

  // memories
  logic [TicksW+SlotW:0]    seg_mem   [QUEUE_DEPTH];
  logic [AXES+StepsW-1:0]   head_mem  [QUEUE_DEPTH];
  logic [StepsW-1:0]        steps_mem [QUEUE_DEPTH*AXES];
  logic [ErrW-1:0]          err_mem   [QUEUE_DEPTH*AXES];

  logic [TicksW+SlotW:0]    seg_rdata_q;
  logic [AXES+StepsW-1:0]   head_rdata_q;
  logic [StepsW-1:0]        steps_rdata_q;
  logic [ErrW-1:0]          err_rdata_q;

  // control state
  state_e                   state_q, state_d;
  logic [AXES-1:0]          inv_q;
  logic [SlotW-1:0]         wslot_q, rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0]          used_q;
  logic                     run_q, fresh_q, out_valid_q;
  logic [AXES-1:0]          cur_dirs_q;
  logic [IdxW-1:0]          idx_q;
  logic                     pend_q;
  logic [AxW-1:0]           pidx_q;

  // captured beat and working registers
  op_e                      op_q;
  logic [AxIdxW-1:0]        ax_q;
  logic [StepsW-1:0]        steps_q, total_q;
  logic [AXES-1:0]          dirs_q;
  logic [TicksW-1:0]        ticks_q;
  logic                     motion_q, last_q;
  logic [PosW-1:0]          posv_q;
  logic [TicksW-1:0]        cur_ticks_q;
  logic                     cur_mot_q;
  logic [SlotW-1:0]         cur_slot_q;
  logic [AXES-1:0]          blk_dirs_q, mask_q;
  logic [StepsW-1:0]        tot_q;
  logic                     rej_q, done_q;
  logic [PosW-1:0]          pos_q [AXES];

  logic [AXES-1:0]          step_q, dir_q;
  logic                     running_q, rejected_q, segdone_q;
  logic [CntW-1:0]          qcount_q;
  logic [PosW-1:0]          axpos_q;

  // memory control
  logic                     seg_re, seg_we, head_re, head_we, ax_re, steps_we, err_we;
  logic [SlotW-1:0]         seg_raddr, head_raddr;
  logic [AddrW-1:0]         ax_raddr, ax_waddr, base_addr, wbase_addr;
  logic [ErrW-1:0]          err_wdata;

  logic                     in_fire, ax_ok, push_ok;
  logic [ErrW-1:0]          e_sum;
  logic                     e_step;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign ax_ok      = ax_q < AxIdxW'(AXES);
  assign push_ok    = (used_q != CntW'(QUEUE_DEPTH)) && (ticks_q != '0);
  assign base_addr  = AddrW'(cur_slot_q) * AddrW'(AXES);
  assign wbase_addr = AddrW'(wslot_q) * AddrW'(AXES);

  // bresenham accumulate and compare for the axis in flight
  assign e_sum  = err_rdata_q + {1'b0, steps_rdata_q};
  assign e_step = e_sum > {1'b0, tot_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: begin
        case (op_q)
          OP_START_BLK: state_d = ST_INIT;
          OP_TICK: begin
            if (run_q)            state_d = ST_BLK;
            else if (used_q != 0) state_d = ST_SEG;
            else                  state_d = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_INIT: if (idx_q == IdxW'(AXES - 1)) state_d = ST_OUT;
      ST_SEG:  state_d = ST_BLK;
      ST_BLK:  state_d = cur_mot_q ? ST_AXIS : ST_FIN;
      ST_AXIS: if (!pend_q && idx_q == IdxW'(AXES)) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory strobes and addresses
  always_comb begin
    seg_re     = 1'b0;
    seg_we     = 1'b0;
    head_re    = 1'b0;
    head_we    = 1'b0;
    ax_re      = 1'b0;
    steps_we   = 1'b0;
    err_we     = 1'b0;
    seg_raddr  = rd_ptr_q;
    head_raddr = cur_slot_q;
    ax_raddr   = base_addr + AddrW'(idx_q);
    ax_waddr   = base_addr + AddrW'(pidx_q);
    err_wdata  = e_step ? (e_sum - {1'b0, tot_q}) : e_sum;
    case (state_q)
      ST_EXEC: begin
        case (op_q)
          OP_LOAD_AXIS: begin
            steps_we = ax_ok;
            ax_waddr = wbase_addr + AddrW'(ax_q);
          end
          OP_START_BLK: head_we = 1'b1;
          OP_PUSH_SEG:  seg_we  = push_ok;
          OP_TICK: begin
            seg_re  = !run_q;
            head_re = run_q;
          end
          default: ;
        endcase
      end
      ST_INIT: begin
        err_we    = 1'b1;
        ax_waddr  = wbase_addr + AddrW'(idx_q);
        err_wdata = {1'b0, total_q} >> 1;
      end
      ST_SEG: begin
        head_re    = 1'b1;
        head_raddr = seg_rdata_q[SlotW-1:0];
      end
      ST_AXIS: begin
        ax_re  = idx_q < IdxW'(AXES);
        err_we = pend_q;
      end
      default: ;
    endcase
  end

  // segment queue memory
  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[wr_ptr_q] <= {ticks_q, motion_q, wslot_q};
    if (seg_re) seg_rdata_q <= seg_mem[seg_raddr];
  end

  // block head memory: directions and total
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[wslot_q] <= {dirs_q, total_q};
    if (head_re) head_rdata_q <= head_mem[head_raddr];
  end

  // per-axis step counts and error accumulators
  always_ff @(posedge clk_i) begin
    if (steps_we) steps_mem[ax_waddr] <= steps_q;
    if (err_we)   err_mem[ax_waddr]   <= err_wdata;
    if (ax_re) begin
      steps_rdata_q <= steps_mem[ax_raddr];
      err_rdata_q   <= err_mem[ax_raddr];
    end
  end

  // captured beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_e'(op_i);
      ax_q     <= axis_index_i;
      steps_q  <= axis_steps_i;
      dirs_q   <= dir_bits_i;
      total_q  <= total_steps_i;
      ticks_q  <= segment_ticks_i;
      motion_q <= has_motion_i;
      last_q   <= last_of_block_i;
      posv_q   <= position_value_i;
    end
  end

  // working registers of the running segment
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEG) begin
      cur_ticks_q <= seg_rdata_q[TicksW+SlotW:SlotW+1];
      cur_mot_q   <= seg_rdata_q[SlotW];
      cur_slot_q  <= seg_rdata_q[SlotW-1:0];
    end else if (state_q == ST_BLK) begin
      cur_ticks_q <= cur_ticks_q - 1'b1;
    end
    if (state_q == ST_BLK) begin
      blk_dirs_q <= head_rdata_q[AXES+StepsW-1:StepsW];
      tot_q      <= head_rdata_q[StepsW-1:0];
    end
    if (state_q == ST_AXIS) pidx_q <= idx_q[AxW-1:0];
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inv_q       <= '0;
      wslot_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      used_q      <= '0;
      run_q       <= 1'b0;
      fresh_q     <= 1'b0;
      cur_dirs_q  <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      mask_q      <= '0;
      rej_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) pos_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) inv_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_EXEC: begin
          mask_q  <= '0;
          rej_q   <= 1'b0;
          done_q  <= 1'b0;
          idx_q   <= '0;
          pend_q  <= 1'b0;
          fresh_q <= 1'b0;
          case (op_q)
            OP_PUSH_SEG: begin
              if (push_ok) begin
                wr_ptr_q <= (wr_ptr_q == SlotW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
                used_q   <= used_q + 1'b1;
                if (last_q)
                  wslot_q <= (wslot_q == SlotW'(QUEUE_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
              end else begin
                rej_q <= 1'b1;
              end
            end
            OP_SET_POS: if (ax_ok) pos_q[ax_q[AxW-1:0]] <= posv_q;
            OP_CLEAR: begin
              rd_ptr_q <= '0;
              wr_ptr_q <= '0;
              used_q   <= '0;
              run_q    <= 1'b0;
              wslot_q  <= '0;
            end
            default: ;
          endcase
        end
        ST_INIT: idx_q <= idx_q + 1'b1;
        ST_SEG: begin
          run_q   <= 1'b1;
          fresh_q <= 1'b1;
        end
        ST_BLK: begin
          if (fresh_q && cur_mot_q) cur_dirs_q <= head_rdata_q[AXES+StepsW-1:StepsW];
        end
        ST_AXIS: begin
          if (idx_q < IdxW'(AXES)) idx_q <= idx_q + 1'b1;
          pend_q <= idx_q < IdxW'(AXES);
          // one axis per cycle: step, mask and position
          if (pend_q && e_step) begin
            for (int i = 0; i < AXES; i++) begin
              if (pidx_q == AxW'(i)) begin
                mask_q[i] <= 1'b1;
                pos_q[i]  <= blk_dirs_q[i] ? pos_q[i] - 1'b1 : pos_q[i] + 1'b1;
              end
            end
          end
        end
        ST_FIN: begin
          if (cur_ticks_q == '0) begin
            rd_ptr_q <= (rd_ptr_q == SlotW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
            used_q   <= used_q - 1'b1;
            run_q    <= 1'b0;
            done_q   <= 1'b1;
          end
        end
        ST_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      step_q     <= mask_q ^ inv_q;
      dir_q      <= cur_dirs_q;
      running_q  <= run_q;
      qcount_q   <= used_q;
      rejected_q <= rej_q;
      segdone_q  <= done_q;
      axpos_q    <= ax_ok ? pos_q[ax_q[AxW-1:0]] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_pins_o     = step_q;
  assign dir_pins_o      = dir_q;
  assign running_o       = running_q;
  assign queue_count_o   = qcount_q;
  assign rejected_o      = rejected_q;
  assign segment_done_o  = segdone_q;
  assign axis_position_o = axpos_q;

`ifndef NO_ASSERTIONS
  // queue fill never exceeds its depth
  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(QUEUE_DEPTH))
    else $error("segment queue over-filled");

  // a running segment always sits in the queue
  a_run_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> used_q != '0)
    else $error("running with an empty queue");

  // a finished segment leaves the generator idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && segdone_q |-> !running_q)
    else $error("segment done while still running");

  // a rejected push changes no queue pointer
  a_rej_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && (op_q == OP_PUSH_SEG) && !push_ok |=> $stable(wr_ptr_q))
    else $error("rejected push moved the write pointer");
`endif

endmodule
